### design/id_free_list_with_reuse_delay_unit_defines.svh
// Assertion macros shared by the id free list controller and datapath.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef ID_FREE_LIST_WITH_REUSE_DELAY_UNIT_DEFINES_SVH
`define ID_FREE_LIST_WITH_REUSE_DELAY_UNIT_DEFINES_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define IFL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("id free list: same-cycle check failed");

// Next-cycle implication: whenever ante holds, cons must hold in the following cycle.
`define IFL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("id free list: next-cycle check failed");

`endif

### design/ifl_pkg.sv
// Package for the id free list with reuse delay: sizes, codes and the
// controller/datapath command and status structs. No dependencies.
package ifl_pkg;

  localparam int ID_COUNT    = 256;
  localparam int ID_W        = 8;
  localparam int CMD_W       = 2;
  localparam int STAT_W      = 2;
  localparam int TIME_W      = 32;
  localparam int RING_AW     = $clog2(ID_COUNT);
  localparam int STAMP_DEPTH = 2 ** ID_W;

  localparam logic [TIME_W-1:0] REUSE_DELAY_RESET = TIME_W'(1000);
  localparam logic [ID_W-1:0]   FAIL_ID           = ID_W'(ID_COUNT - 1);
  localparam logic [ID_W-1:0]   FRESH_RESET       = ID_W'(ID_COUNT - 1);

  // Request command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_TICK    = 2'd2
  } cmd_code_t;

  // Response status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_NO_ID     = 2'd1,
    ST_RING_FULL = 2'd2
  } status_t;

  // How a finished transaction updates state and what it reports.
  typedef enum logic [2:0] {
    ACT_FRESH,
    ACT_POP,
    ACT_FAIL,
    ACT_PUSH,
    ACT_FULL
  } act_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;
    logic tick;
    logic ring_rd;
    logic stamp_rd;
    logic finish;
    act_t act;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fresh_avail;
    logic ring_empty;
    logic ring_full;
    logic too_fresh;
    logic out_free;
  } dp_stat_t;

  // Advance a ring index, wrapping at ID_COUNT.
  function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] idx);
    logic [RING_AW-1:0] res;
    if (idx == RING_AW'(ID_COUNT - 1)) begin
      res = '0;
    end else begin
      res = idx + 1'b1;
    end
    return res;
  endfunction

endpackage

### design/ifl_channels.sv
// Handshake channel interfaces for the id free list: request, response and
// configuration write. Depends on ifl_pkg for field widths.
interface ifl_req_if;
  import ifl_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [ID_W-1:0]  release_id;
  modport source(output valid, command, release_id, input ready);
  modport sink(input valid, command, release_id, output ready);
endinterface

interface ifl_rsp_if;
  import ifl_pkg::*;
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   issued_id;
  logic [STAT_W-1:0] status;
  modport source(output valid, issued_id, status, input ready);
  modport sink(input valid, issued_id, status, output ready);
endinterface

interface ifl_cfg_if;
  import ifl_pkg::*;
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

### design/ifl_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ifl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/ifl_ctrl.sv
// Controller state machine for the id free list: sequences request
// transactions into datapath commands. Depends on ifl_pkg and the defines header.
`include "id_free_list_with_reuse_delay_unit_defines.svh"

module ifl_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  input  logic [ifl_pkg::CMD_W-1:0] req_command,
  output logic                    req_ready,
  input  ifl_pkg::dp_stat_t       stat,
  output ifl_pkg::dp_cmd_t        cmd
);
  import ifl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_STAMP_RD,
    S_CHECK,
    S_FINISH
  } state_t;

  state_t state, state_next;
  act_t   act, act_next;
  logic   accept;

  // Next state and per-cycle datapath commands.
  always_comb begin
    req_ready  = (state == S_IDLE) && !rst;
    accept     = req_valid && req_ready;
    state_next = state;
    act_next   = act;
    cmd        = '0;
    cmd.act    = act;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.latch = 1'b1;
          case (cmd_code_t'(req_command))
            CMD_ALLOC: begin
              if (stat.fresh_avail) begin
                act_next   = ACT_FRESH;
                state_next = S_FINISH;
              end else if (stat.ring_empty) begin
                act_next   = ACT_FAIL;
                state_next = S_FINISH;
              end else begin
                cmd.ring_rd = 1'b1;
                state_next  = S_STAMP_RD;
              end
            end
            CMD_RELEASE: begin
              act_next   = stat.ring_full ? ACT_FULL : ACT_PUSH;
              state_next = S_FINISH;
            end
            CMD_TICK: begin
              cmd.tick = 1'b1;
            end
            default: ;
          endcase
        end
      end
      S_STAMP_RD: begin
        // Oldest ring entry is out of the RAM; look up its release stamp.
        cmd.stamp_rd = 1'b1;
        state_next   = S_CHECK;
      end
      S_CHECK: begin
        act_next   = stat.too_fresh ? ACT_FAIL : ACT_POP;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and the registered finishing action.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      act   <= ACT_FAIL;
    end else begin
      state <= state_next;
      act   <= act_next;
    end
  end

  `IFL_ASSERT_NXT(a_stamp_after_ring, cmd.ring_rd, cmd.stamp_rd)
  `IFL_ASSERT_IMP(a_finish_needs_slot, cmd.finish, stat.out_free)
  `IFL_ASSERT_NXT(a_ready_after_finish, cmd.finish, req_ready)

endmodule

### design/ifl_dpath.sv
// Datapath for the id free list: time, counters, ring pointers, the ring and
// stamp RAMs and the response register. Depends on ifl_pkg, ifl_ram and the defines header.
`include "id_free_list_with_reuse_delay_unit_defines.svh"

module ifl_dpath (
  input  logic                       clk,
  input  logic                       rst,
  input  ifl_pkg::dp_cmd_t           cmd,
  output ifl_pkg::dp_stat_t          stat,
  input  logic [ifl_pkg::ID_W-1:0]   req_release_id,
  input  logic                       cfg_valid,
  input  logic [ifl_pkg::TIME_W-1:0] cfg_data,
  output logic                       cfg_ready,
  input  logic                       rsp_ready,
  output logic                       rsp_valid,
  output logic [ifl_pkg::ID_W-1:0]   rsp_issued_id,
  output logic [ifl_pkg::STAT_W-1:0] rsp_status
);
  import ifl_pkg::*;

  logic [TIME_W-1:0]  reuse_delay;
  logic [TIME_W-1:0]  time_now;
  logic [ID_W-1:0]    fresh_left;
  logic [RING_AW-1:0] ring_head;
  logic [RING_AW-1:0] ring_tail;
  logic [ID_W-1:0]    rid;
  logic [ID_W-1:0]    ring_q;
  logic [TIME_W-1:0]  stamp_q;
  logic [TIME_W-1:0]  age;
  logic               push;
  logic [ID_W-1:0]    issued_next;
  status_t            status_next;

  assign cfg_ready = !rst;
  assign push      = cmd.finish && (cmd.act == ACT_PUSH);

  // Free ring of released ids, oldest at the tail.
  ifl_ram #(.WIDTH(ID_W), .DEPTH(ID_COUNT)) u_ring_ram (
    .clk   (clk),
    .we    (push),
    .waddr (ring_head),
    .wdata (rid),
    .re    (cmd.ring_rd),
    .raddr (ring_tail),
    .rdata (ring_q)
  );

  // Release time of each id, addressed by the id itself.
  ifl_ram #(.WIDTH(TIME_W), .DEPTH(STAMP_DEPTH)) u_stamp_ram (
    .clk   (clk),
    .we    (push),
    .waddr (rid),
    .wdata (time_now),
    .re    (cmd.stamp_rd),
    .raddr (ring_q),
    .rdata (stamp_q)
  );

  // Status for the controller; age uses the wrapping difference.
  always_comb begin
    age              = time_now - stamp_q;
    stat.fresh_avail = (fresh_left != '0);
    stat.ring_empty  = (ring_head == ring_tail);
    stat.ring_full   = (ring_next(ring_head) == ring_tail);
    stat.too_fresh   = (age < reuse_delay);
    stat.out_free    = !rsp_valid || rsp_ready;
  end

  // Response payload for the finishing action.
  always_comb begin
    case (cmd.act)
      ACT_FRESH: begin
        issued_next = fresh_left;
        status_next = ST_OK;
      end
      ACT_POP: begin
        issued_next = ring_q;
        status_next = ST_OK;
      end
      ACT_PUSH: begin
        issued_next = rid;
        status_next = ST_OK;
      end
      ACT_FULL: begin
        issued_next = rid;
        status_next = ST_RING_FULL;
      end
      default: begin
        issued_next = FAIL_ID;
        status_next = ST_NO_ID;
      end
    endcase
  end

  // Control registers: configuration, time, counters, pointers, response valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      reuse_delay <= REUSE_DELAY_RESET;
      time_now    <= '0;
      fresh_left  <= FRESH_RESET;
      ring_head   <= '0;
      ring_tail   <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        reuse_delay <= cfg_data;
      end
      if (cmd.tick) begin
        time_now <= time_now + 1'b1;
      end
      if (cmd.finish) begin
        rsp_valid <= 1'b1;
        case (cmd.act)
          ACT_FRESH: fresh_left <= fresh_left - 1'b1;
          ACT_POP:   ring_tail  <= ring_next(ring_tail);
          ACT_PUSH:  ring_head  <= ring_next(ring_head);
          default: ;
        endcase
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Payload registers: latched release id and the response fields.
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      rid <= req_release_id;
    end
    if (cmd.finish) begin
      rsp_issued_id <= issued_next;
      rsp_status    <= status_next;
    end
  end

  `IFL_ASSERT_IMP(a_push_not_full, push, !stat.ring_full)
  `IFL_ASSERT_IMP(a_pop_not_empty, cmd.finish && (cmd.act == ACT_POP), !stat.ring_empty)
  `IFL_ASSERT_IMP(a_fresh_nonzero, cmd.finish && (cmd.act == ACT_FRESH), fresh_left != '0)

endmodule

### design/id_free_list_with_reuse_delay_unit.sv
// Channel   Role    Payload
// req       sink    command, release_id
// rsp       source  issued_id, status
// cfg       sink    data (reuse_delay)
//
// A tick only advances time; a release, an allocate of a never-used id and one
// that fails on an empty ring go straight to the finish state; an allocate from
// the free ring first does the ring RAM read and then the stamp RAM read, each
// with a registered output. Finish waits while a response waits on rsp.ready.
// Reset is synchronous and takes effect at once: the RAMs are not cleared.
// Configuration writes are taken in every cycle outside reset.
//
// Top level of the id free list with reuse delay. Depends on ifl_pkg,
// ifl_channels, ifl_ctrl and ifl_dpath.
module id_free_list_with_reuse_delay_unit (
  input logic      clk,
  input logic      rst,
  ifl_req_if.sink  req,
  ifl_rsp_if.source rsp,
  ifl_cfg_if.sink  cfg
);
  import ifl_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer for request transactions.
  ifl_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req.valid),
    .req_command (req.command),
    .req_ready   (req.ready),
    .stat        (stat),
    .cmd         (cmd)
  );

  // State, memories and response register.
  ifl_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .req_release_id (req.release_id),
    .cfg_valid      (cfg.valid),
    .cfg_data       (cfg.data),
    .cfg_ready      (cfg.ready),
    .rsp_ready      (rsp.ready),
    .rsp_valid      (rsp.valid),
    .rsp_issued_id  (rsp.issued_id),
    .rsp_status     (rsp.status)
  );

endmodule

### verif/tb_id_free_list_with_reuse_delay_unit.sv
// Self-checking testbench for the id free list with reuse delay.
// Depends on ifl_pkg, the ifl channel interfaces and the top-level RTL.
module tb_id_free_list_with_reuse_delay_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import ifl_pkg::*;

  localparam logic [CMD_W-1:0]  CMD_UNUSED     = 2'd3;
  localparam logic [TIME_W-1:0] DELAY_AT_RESET = TIME_W'(1000);
  localparam logic [TIME_W-1:0] DELAY_NONE     = '0;
  localparam logic [TIME_W-1:0] DELAY_FOREVER  = '1;
  localparam logic [TIME_W-1:0] DELAY_SHORT    = TIME_W'(1);
  localparam int SETTLE_CYCLES = 24;
  localparam int CYCLE_LIMIT   = 500000;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic [ID_W-1:0]  rid;
  } request_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    status_t         status;
  } reply_t;

  logic clk = 1'b0;
  logic rst;

  ifl_req_if req_ch();
  ifl_rsp_if rsp_ch();
  ifl_cfg_if cfg_ch();

  id_free_list_with_reuse_delay_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // Shadow copy of the allocator state.
  logic [TIME_W-1:0] hold_ticks;
  logic [TIME_W-1:0] clock_ticks;
  int                fresh_count;
  int                ring_wr;
  int                ring_rd;
  logic [ID_W-1:0]   free_ids [ID_COUNT];
  logic [TIME_W-1:0] freed_at [2**ID_W];

  request_t pending_requests[$];
  reply_t   awaited_replies[$];
  int       queued_count;
  int       accepted_count;
  int       errors;
  int       cycle_count;
  logic     req_fire;
  logic     cfg_fire;

  // Driver state.
  request_t    next_req;
  int          burst_left;
  int          gap_left;
  logic [15:0] accept_mask;
  int          stall_clock;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work out the reply to one accepted request and update the shadow state.
  task automatic apply_request(input logic [CMD_W-1:0] op, input logic [ID_W-1:0] rid);
    reply_t            r;
    logic [ID_W-1:0]   oldest;
    logic [TIME_W-1:0] age;
    int                held;
    case (op)
      CMD_ALLOC: begin
        if (fresh_count != 0) begin
          r.id = ID_W'(fresh_count);
          r.status = ST_OK;
          fresh_count--;
        end else if (ring_wr == ring_rd) begin
          r.id = FAIL_ID;
          r.status = ST_NO_ID;
        end else begin
          oldest = free_ids[ring_rd];
          age = clock_ticks - freed_at[oldest];
          // A freshly released id stays in the ring and blocks the ones behind it.
          if (age < hold_ticks) begin
            r.id = FAIL_ID;
            r.status = ST_NO_ID;
          end else begin
            r.id = oldest;
            r.status = ST_OK;
            ring_rd = (ring_rd + 1) % ID_COUNT;
          end
        end
        awaited_replies.push_back(r);
      end
      CMD_RELEASE: begin
        r.id = rid;
        held = (ring_wr >= ring_rd) ? ring_wr - ring_rd : ring_wr + ID_COUNT - ring_rd;
        if (held >= ID_COUNT - 1) begin
          r.status = ST_RING_FULL;
        end else begin
          free_ids[ring_wr] = rid;
          ring_wr = (ring_wr + 1) % ID_COUNT;
          freed_at[rid] = clock_ticks;
          r.status = ST_OK;
        end
        awaited_replies.push_back(r);
      end
      CMD_TICK: begin
        clock_ticks = clock_ticks + 1'b1;
      end
      default: begin
      end
    endcase
  endtask

  task automatic queue_one(input logic [CMD_W-1:0] op, input logic [ID_W-1:0] rid);
    request_t t;
    t.op = op;
    t.rid = rid;
    pending_requests.push_back(t);
    queued_count++;
  endtask

  // Random requests; weights are percentages and the remainder is the unused code.
  task automatic queue_requests(input int count, input int w_alloc, input int w_rel,
                                input int w_tick);
    int              roll;
    logic [ID_W-1:0] rid;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      case ($urandom_range(0, 7))
        0: rid = '0;
        1: rid = ID_W'(ID_COUNT - 1);
        default: rid = ID_W'($urandom_range(0, 2**ID_W - 1));
      endcase
      if (roll < w_alloc) begin
        queue_one(CMD_ALLOC, rid);
      end else if (roll < w_alloc + w_rel) begin
        queue_one(CMD_RELEASE, rid);
      end else if (roll < w_alloc + w_rel + w_tick) begin
        queue_one(CMD_TICK, rid);
      end else begin
        queue_one(CMD_UNUSED, rid);
      end
    end
  endtask

  // Block until every queued request is taken and every reply is back, then settle.
  task automatic wait_idle();
    do @(negedge clk);
    while (accepted_count != queued_count || awaited_replies.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_delay(input logic [TIME_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(negedge clk);
    while (!cfg_fire);
    cfg_ch.valid <= 1'b0;
  endtask

  // Request driver: bursts of transactions separated by random gaps.
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_fire) begin
      if (gap_left != 0) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (pending_requests.size() != 0) begin
        next_req = pending_requests.pop_front();
        req_ch.valid <= 1'b1;
        req_ch.command <= next_req.op;
        req_ch.release_id <= next_req.rid;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        end else begin
          burst_left--;
        end
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Reply acceptor: a rotating ready mask, redrawn at random from four kinds of pattern.
  always @(negedge clk) begin
    stall_clock++;
    if (stall_clock % 48 == 0) begin
      case ($urandom_range(0, 3))
        0: accept_mask = '1;
        1: accept_mask = 16'($urandom) | 16'h0001;
        2: accept_mask = 16'($urandom & $urandom) | 16'h0001;
        default: accept_mask = 16'($urandom | $urandom);
      endcase
    end
    accept_mask = {accept_mask[14:0], accept_mask[15]};
    rsp_ch.ready <= accept_mask[0];
  end

  // Monitor: track accepted transactions on all channels and check replies.
  always @(posedge clk) begin
    req_fire <= !rst && req_ch.valid && req_ch.ready;
    cfg_fire <= !rst && cfg_ch.valid && cfg_ch.ready;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        hold_ticks = cfg_ch.data;
      end
      if (req_ch.valid && req_ch.ready) begin
        apply_request(req_ch.command, req_ch.release_id);
        accepted_count++;
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (awaited_replies.size() == 0) begin
          $display("%0t: reply with none awaited: id %0d status %0d", $time,
                   rsp_ch.issued_id, rsp_ch.status);
          errors++;
        end else begin
          if (rsp_ch.issued_id !== awaited_replies[0].id) begin
            $display("%0t: issued_id mismatch: expected %0d, actual %0d", $time,
                     awaited_replies[0].id, rsp_ch.issued_id);
            errors++;
          end
          if (rsp_ch.status !== awaited_replies[0].status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                     awaited_replies[0].status, rsp_ch.status);
            errors++;
          end
          void'(awaited_replies.pop_front());
        end
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Test sequence: reset, directed requests, then randomized phases per delay setting.
  initial begin
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.command = CMD_TICK;
    req_ch.release_id = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    req_fire = 1'b0;
    cfg_fire = 1'b0;
    burst_left = 1;
    gap_left = 0;
    accept_mask = '1;
    stall_clock = 0;
    queued_count = 0;
    accepted_count = 0;
    errors = 0;
    cycle_count = 0;
    hold_ticks = DELAY_AT_RESET;
    clock_ticks = '0;
    fresh_count = ID_COUNT - 1;
    ring_wr = 0;
    ring_rd = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: unused code, extreme ids, duplicate release, fresh allocations.
    @(posedge clk);
    queue_one(CMD_TICK, '0);
    queue_one(CMD_UNUSED, '1);
    queue_one(CMD_RELEASE, '0);
    queue_one(CMD_RELEASE, '1);
    queue_one(CMD_RELEASE, ID_W'(8'hAA));
    queue_one(CMD_RELEASE, ID_W'(8'h55));
    queue_one(CMD_ALLOC, '0);
    queue_one(CMD_ALLOC, '1);
    queue_one(CMD_RELEASE, '0);
    queue_one(CMD_TICK, '1);
    queue_one(CMD_UNUSED, '0);
    // Mostly allocations so the never-used ids run out under the reset delay.
    queue_requests(330, 85, 8, 5);
    wait_idle();

    // No delay: popped ids come back at once and the ring runs empty.
    write_delay(DELAY_NONE);
    @(posedge clk);
    queue_requests(450, 40, 35, 20);
    wait_idle();

    // Short random delay: mix of too-fresh refusals and successful pops.
    write_delay(TIME_W'($urandom_range(2, 12)));
    @(posedge clk);
    queue_requests(450, 40, 30, 28);
    wait_idle();

    // Largest delay: nothing can be reissued, releases fill the ring.
    write_delay(DELAY_FOREVER);
    @(posedge clk);
    queue_requests(340, 6, 90, 3);
    wait_idle();

    // Delay of one tick: drain the ring.
    write_delay(DELAY_SHORT);
    @(posedge clk);
    queue_requests(300, 60, 10, 28);
    wait_idle();

    if (errors == 0 && awaited_replies.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
